[sv/cht_pkg.sv]
// cht_pkg: types and constants for the capability handle table
// no dependencies
package cht_pkg;
  localparam int TableEntries = 16;
  localparam int EntryBits = $clog2(TableEntries);
  localparam int ResourceCount = 256;
  localparam int ResBits = $clog2(ResourceCount);
  localparam int RightsBits = 8;
  localparam int TypeBits = 4;
  localparam logic [15:0] CountMax = 16'hffff;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0, CMD_LOOKUP = 2'd1, CMD_CLOSE = 2'd2, CMD_CLOSE_ALL = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_FULL = 2'd1, ST_NOT_FOUND = 2'd2, ST_TYPE_MISMATCH = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] handle_value;
    logic [7:0]  resource_id;
    logic [3:0]  resource_type;
    logic [7:0]  rights;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_handle;
    logic [7:0]  found_resource;
    logic [15:0] ref_count;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic                 load;
    logic                 scan;
    logic [EntryBits-1:0] idx;
    logic                 cnt_read;
    logic                 cnt_write;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic is_free;
  } dp_stat_t;
endpackage

[sv/cht_ctrl.sv]
// cht_ctrl: sequencer that walks the entries and steps the counter memory
// depends on cht_pkg
module cht_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  cht_pkg::dp_stat_t stat,
  output cht_pkg::dp_cmd_t  cmd,
  output logic              done
);
  import cht_pkg::*;
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_RD, S_WAIT, S_WR, S_OUT} state_t;
  state_t state;
  logic [EntryBits-1:0] idx;
  logic cont;
  logic last;

  assign last = (idx == EntryBits'(TableEntries - 1));
  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && in_valid;
    cmd.scan = (state == S_SCAN);
    cmd.idx = idx;
    cmd.cnt_read = (state == S_RD);
    cmd.cnt_write = (state == S_WR);
  end
  assign done = (state == S_SCAN) && last && !stat.hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      cont <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          state <= S_SCAN;
          idx <= '0;
        end
        S_SCAN: begin
          if (stat.hit) begin
            state <= S_RD;
            cont <= stat.is_free && !last;
          end else if (last) begin
            state <= S_OUT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_RD: state <= S_WAIT;
        S_WAIT: state <= S_WR;
        S_WR: begin
          if (cont) begin
            state <= S_SCAN;
            idx <= idx + 1'b1;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[sv/cht_dp.sv]
// cht_dp: entry registers, handle counter, reference count memory
// depends on cht_pkg
module cht_dp (
  input  logic               clk,
  input  logic               rst,
  input  cht_pkg::in_word_t  in_word,
  input  cht_pkg::dp_cmd_t   cmd,
  input  logic               done,
  output cht_pkg::dp_stat_t  stat,
  output cht_pkg::out_word_t out_word
);
  import cht_pkg::*;
  logic [TableEntries-1:0] entry_valid;
  logic [31:0]           entry_handle [TableEntries];
  logic [7:0]            entry_resource [TableEntries];
  logic [RightsBits-1:0] entry_rights [TableEntries];
  logic [TypeBits-1:0]   entry_type [TableEntries];
  logic [15:0]           cnt_mem [ResourceCount];
  logic [ResourceCount-1:0] cnt_ok;
  logic [31:0] next_handle;
  in_word_t req;
  logic [15:0] rd_cnt;
  logic        rd_ok;
  logic [ResBits-1:0] cnt_addr;
  logic        cnt_up;
  logic        cnt_we;
  logic [15:0] new_cnt;
  logic [31:0] new_handle;
  logic        hit, rights_ok, type_bad;
  logic [EntryBits-1:0] i;

  assign i = cmd.idx;
  assign rights_ok = (entry_rights[i] & req.rights[RightsBits-1:0]) == req.rights[RightsBits-1:0];
  assign type_bad = (req.resource_type[TypeBits-1:0] != '0) &&
                    (entry_type[i] != req.resource_type[TypeBits-1:0]);
  always_comb begin
    case (cmd_t'(req.command))
      CMD_ADD:    hit = !entry_valid[i];
      CMD_LOOKUP: hit = entry_valid[i] && entry_handle[i] == req.handle_value && rights_ok;
      CMD_CLOSE:  hit = entry_valid[i] && entry_handle[i] == req.handle_value;
      default:    hit = entry_valid[i];
    endcase
  end
  assign stat.hit = hit;
  assign stat.is_free = (cmd_t'(req.command) == CMD_CLOSE_ALL);
  assign new_handle = (next_handle == 32'd0) ? 32'd1 : next_handle;
  // lookup only reads the counter
  assign cnt_we = cmd.cnt_write && (cmd_t'(req.command) != CMD_LOOKUP);
  always_comb begin
    if (!rd_ok) new_cnt = 16'd0;
    else new_cnt = rd_cnt;
    if (cnt_up) begin
      if (new_cnt != CountMax) new_cnt = new_cnt + 16'd1;
    end else if (new_cnt != 16'd0) begin
      new_cnt = new_cnt - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_read) begin
      rd_cnt <= cnt_mem[cnt_addr];
      rd_ok <= cnt_ok[cnt_addr];
    end
    if (cnt_we) cnt_mem[cnt_addr] <= new_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      cnt_ok <= '0;
      next_handle <= 32'd1;
    end else begin
      if (cnt_we) cnt_ok[cnt_addr] <= 1'b1;
      if (cmd.scan && hit && cmd_t'(req.command) == CMD_ADD) begin
        entry_valid[i] <= 1'b1;
        next_handle <= new_handle + 32'd1;
      end else if (cmd.scan && hit && cmd_t'(req.command) != CMD_LOOKUP) begin
        entry_valid[i] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= in_word;
      out_word <= '0;
    end
    if (done) begin
      if (cmd_t'(req.command) == CMD_ADD) out_word.status <= ST_FULL;
      else if (cmd_t'(req.command) != CMD_CLOSE_ALL) out_word.status <= ST_NOT_FOUND;
    end
    if (cmd.scan && hit) begin
      case (cmd_t'(req.command))
        CMD_ADD: begin
          entry_handle[i] <= new_handle;
          entry_resource[i] <= req.resource_id;
          entry_rights[i] <= req.rights[RightsBits-1:0];
          entry_type[i] <= req.resource_type[TypeBits-1:0];
          cnt_addr <= req.resource_id[ResBits-1:0];
          cnt_up <= 1'b1;
          out_word.status <= ST_OK;
          out_word.result_handle <= new_handle;
          out_word.found_resource <= req.resource_id;
        end
        CMD_LOOKUP: begin
          cnt_addr <= entry_resource[i][ResBits-1:0];
          cnt_up <= 1'b0;
          if (type_bad) out_word.status <= ST_TYPE_MISMATCH;
          else begin
            out_word.status <= ST_OK;
            out_word.found_resource <= entry_resource[i];
          end
        end
        default: begin
          cnt_addr <= entry_resource[i][ResBits-1:0];
          cnt_up <= 1'b0;
          if (cmd_t'(req.command) == CMD_CLOSE) begin
            out_word.status <= ST_OK;
            out_word.found_resource <= entry_resource[i];
          end
        end
      endcase
    end
    if (cmd.cnt_write && cmd_t'(req.command) != CMD_CLOSE_ALL &&
        out_word.status == ST_OK) begin
      if (cmd_t'(req.command) == CMD_LOOKUP) out_word.ref_count <= rd_ok ? rd_cnt : 16'd0;
      else out_word.ref_count <= new_cnt;
    end
  end
endmodule

[sv/capability_handle_table.sv]
// capability_handle_table: top level, joins sequencer and datapath
// depends on cht_pkg, cht_ctrl, cht_dp
//
// usage
//   input channel in/in_valid/in_stall carries one command word
//   output channel out/out_valid/out_stall returns one result word
//   a command is taken only while the block is idle; one at a time
//   operation: the walk visits the table entries (16 entries) in order; each
//   entry that touches a reference count steps the counter memory through
//   read, wait and write; then the result is presented
//   add/lookup/close stop at the first hit; close all walks every entry
//   the walk through the entries and the counter steps set the rate
//   reset clears all entries, sets the next handle to one and marks every
//   reference counter as zero through per-counter valid bits
//   while the receiver stalls the result word holds and no command is taken
module capability_handle_table (
  input  logic               clk,
  input  logic               rst,
  input  cht_pkg::in_word_t  in,
  input  logic               in_valid,
  output logic               in_stall,
  output cht_pkg::out_word_t out,
  output logic               out_valid,
  input  logic               out_stall
);
  import cht_pkg::*;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     done;

  cht_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .stat, .cmd, .done
  );
  cht_dp u_dp (
    .clk, .rst, .in_word(in), .cmd, .done, .stat, .out_word(out)
  );
endmodule

[sv/cht_checker.sv]
// cht_checker: port-level assertions for capability_handle_table
// depends on cht_pkg; bound to the top level
module cht_checker (
  input logic               clk,
  input logic               rst,
  input cht_pkg::in_word_t  in,
  input logic               in_valid,
  input logic               in_stall,
  input cht_pkg::out_word_t out,
  input logic               out_valid,
  input logic               out_stall
);
  import cht_pkg::*;
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out)) else $error("result word moved");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken during result");
  a_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall && !out_valid) else $error("no work after accept");
  a_handle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out.status != ST_OK |-> out.result_handle == 32'd0)
    else $error("handle on failure");
endmodule

bind capability_handle_table cht_checker u_chk (.*);
